FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that holds on every clock edge out of reset.
`define FSF_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
// Same-cycle implication.
`define FSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
// Next-cycle implication.
`define FSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`endif

FILE: hdl/fsf_pkg.sv
// Package for the saturating FIR filter: types, constants, coefficient ROM.
// No dependencies.
package fsf_pkg;
    localparam int COEF_WIDTH = 16;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = COEF_WIDTH - 1;
    localparam int PROD_W     = COEF_WIDTH + SAMPLE_W;
    localparam int ROM_TAPS   = 201;
    localparam int ROM_MID    = 100;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    // first half of the symmetric low-pass taps, Q1.15
    localparam logic signed [COEF_WIDTH-1:0] HALF_ROM [0:ROM_MID] = '{
        16'sd23, 16'sd22, 16'sd19, 16'sd13, 16'sd6, -16'sd1, -16'sd8, -16'sd14,
        -16'sd17, -16'sd18, -16'sd14, -16'sd7, 16'sd4, 16'sd17, 16'sd34, 16'sd51,
        16'sd69, 16'sd84, 16'sd98, 16'sd107, 16'sd111, 16'sd110, 16'sd104, 16'sd92,
        16'sd76, 16'sd57, 16'sd36, 16'sd15, -16'sd4, -16'sd19, -16'sd29, -16'sd33,
        -16'sd31, -16'sd22, -16'sd8, 16'sd9, 16'sd29, 16'sd48, 16'sd65, 16'sd76,
        16'sd79, 16'sd73, 16'sd57, 16'sd31, -16'sd5, -16'sd49, -16'sd99, -16'sd151,
        -16'sd203, -16'sd249, -16'sd288, -16'sd314, -16'sd327, -16'sd325, -16'sd306,
        -16'sd273, -16'sd228, -16'sd172, -16'sd112, -16'sd51, 16'sd5, 16'sd52,
        16'sd85, 16'sd103, 16'sd102, 16'sd84, 16'sd49, 16'sd1, -16'sd54, -16'sd110,
        -16'sd162, -16'sd200, -16'sd218, -16'sd210, -16'sd171, -16'sd99, 16'sd6,
        16'sd142, 16'sd303, 16'sd483, 16'sd671, 16'sd855, 16'sd1024, 16'sd1165,
        16'sd1265, 16'sd1314, 16'sd1305, 16'sd1232, 16'sd1094, 16'sd894, 16'sd637,
        16'sd332, -16'sd6, -16'sd362, -16'sd720, -16'sd1062, -16'sd1369, -16'sd1627,
        -16'sd1822, -16'sd1943, 16'sd30784
    };

    // tap k coefficient; mirrored upper half, zero past the ROM
    function automatic logic signed [COEF_WIDTH-1:0] fsf_coef(input logic [8:0] k);
        logic [8:0] m;
        m = (k > 9'(ROM_MID)) ? 9'(9'(ROM_TAPS - 1) - k) : k;
        if (k >= 9'(ROM_TAPS)) return '0;
        return HALF_ROM[m[6:0]];
    endfunction
endpackage

FILE: hdl/fsf_if.sv
// Valid/ready stream interfaces for the FIR filter input and output words.
// Depends on fsf_pkg.
interface fsf_in_if import fsf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] audio_in;
    modport source (output valid, output audio_in, input ready);
    modport sink   (input valid, input audio_in, output ready);
endinterface

interface fsf_out_if import fsf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] audio_out;
    modport source (output valid, output audio_out, input ready);
    modport sink   (input valid, input audio_out, output ready);
endinterface

FILE: hdl/fsf_mac.sv
// Shared multiply-accumulate unit: registered product, then wide accumulate.
// Depends on fsf_pkg.
module fsf_mac import fsf_pkg::*; #(
    parameter int ACC_W = 41
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mac_ctl                     i_ctl,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    input  logic signed [COEF_WIDTH-1:0] i_coef,
    output logic signed [ACC_W-1:0]      o_acc
);
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.en;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;
endmodule

FILE: hdl/fir_filter_saturating.sv
// Top level of the saturating direct-form FIR filter.
// Depends on fsf_pkg, fsf_if, fsf_mac and assert_macros.svh.
//
//  port    dir  modport  payload          use
//  i_in    in   sink     audio_in  [15:0] sample x[n]
//  o_out   out  source   audio_out [15:0] filtered, saturated y[n]
//
// A word is taken only in the idle state, so the next waits until this one is done:
// one shared MAC walks the delay line one tap per cycle (one memory read
// port), then the drain state, then the finish state for shift and saturation.
// Reset clears the per-entry valid bits, so the delay line reads as zero.
// A finished result sits in the output register; a stalled output only
// holds the block once the next result is ready too.
`include "assert_macros.svh"
module fir_filter_saturating import fsf_pkg::*; #(
    parameter int TAPS = 201
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsf_in_if.sink    i_in,
    fsf_out_if.source o_out
);
    localparam int PW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = PROD_W + PW + 1;
    localparam logic [PW-1:0] LAST = PW'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] RND   = ACC_W'((1 << FRAC_BITS) - 1);

    t_state r_state, n_state;

    // delay line memory and its valid bits
    logic signed [SAMPLE_W-1:0] r_mem [TAPS];
    logic [TAPS-1:0]            r_vld;

    logic [PW-1:0]              r_wp;
    logic [PW-1:0]              r_rd_ptr;
    logic [PW-1:0]              r_k;
    logic [1:0]                 r_dc;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_v;
    logic signed [COEF_WIDTH-1:0] r_coef;
    logic                       r_p1;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_vld;

    logic                       s_accept;
    logic                       s_run;
    logic                       s_load;
    logic                       s_take;
    t_mac_ctl                   s_ctl;
    logic signed [ACC_W-1:0]    s_acc;
    logic signed [ACC_W-1:0]    s_adj;
    logic signed [ACC_W-1:0]    s_q;
    logic signed [SAMPLE_W-1:0] s_sat;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_accept) n_state = S_RUN;
            S_RUN:   if (r_k == LAST) n_state = S_DRAIN;
            S_DRAIN: if (r_dc == 2'd3) n_state = S_FIN;
            S_FIN:   if (!r_out_vld || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready = 1'b0;
        s_run      = 1'b0;
        s_load     = 1'b0;
        unique case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_RUN:   s_run = 1'b1;
            S_DRAIN: ;
            S_FIN:   s_load = !r_out_vld || o_out.ready;
            default: ;
        endcase
    end

    assign s_accept  = i_in.valid && i_in.ready;
    assign s_take    = o_out.valid && o_out.ready;
    assign s_ctl.clr = s_accept;
    assign s_ctl.en  = r_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_wp      <= '0;
            r_rd_ptr  <= '0;
            r_k       <= '0;
            r_dc      <= '0;
            r_p1      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= s_run;
            if (s_accept) begin
                r_vld[r_wp] <= 1'b1;
                r_rd_ptr    <= r_wp;
                r_k         <= '0;
                r_dc        <= '0;
            end
            if (s_run) begin
                r_rd_ptr <= (r_rd_ptr == '0) ? LAST : r_rd_ptr - PW'(1);
                r_k      <= r_k + PW'(1);
                if (r_k == LAST) begin
                    r_wp <= (r_wp == LAST) ? '0 : r_wp + PW'(1);
                end
            end
            if (r_state == S_DRAIN) begin
                r_dc <= r_dc + 2'd1;
            end
            if (s_load) begin
                r_out_vld <= 1'b1;
            end else if (s_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // memory write/read and the operand stage
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mem[r_wp] <= i_in.audio_in;
        end
        r_rd_data <= r_mem[r_rd_ptr];
        r_rd_v    <= r_vld[r_rd_ptr];
        r_coef    <= fsf_coef(9'(r_k));
        if (s_load) begin
            r_out <= s_sat;
        end
    end

    fsf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_sample (r_rd_v ? r_rd_data : '0),
        .i_coef   (r_coef),
        .o_acc    (s_acc)
    );

    // shift toward zero, then clamp
    always_comb begin
        s_adj = s_acc[ACC_W-1] ? s_acc + RND : s_acc;
        s_q   = s_adj >>> FRAC_BITS;
        priority if (s_q > Q_MAX) begin
            s_sat = SAMPLE_W'(Q_MAX);
        end else if (s_q < Q_MIN) begin
            s_sat = SAMPLE_W'(Q_MIN);
        end else begin
            s_sat = s_q[SAMPLE_W-1:0];
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.audio_out = r_out;

    `FSF_ASSERT(a_wp_range, i_clk, i_rst_n, r_wp <= LAST)
    `FSF_ASSERT_NXT(a_start, i_clk, i_rst_n, s_accept, r_state == S_RUN && r_k == '0)
    `FSF_ASSERT_IMP(a_out_src, i_clk, i_rst_n, $rose(r_out_vld), $past(r_state) == S_FIN)
endmodule

FILE: bench/tb.sv
// Self-checking bench for the saturating FIR filter: drives sample words,
// predicts each filtered word with its own tap walk, and compares in order.
// Depends on fsf_pkg, fsf_if and the fir_filter_saturating RTL.
module tb;
    import fsf_pkg::*;

    localparam int NTAPS      = 201;
    localparam int WATCHDOG   = 20000;
    localparam int RAND_ITEMS = 780;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsf_in_if  in_ch ();
    fsf_out_if out_ch ();

    fir_filter_saturating #(.TAPS(NTAPS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // predictor state: sample history and its write slot
    logic signed [SAMPLE_W-1:0] hist [0:NTAPS-1];
    int unsigned                hist_wr;
    logic signed [SAMPLE_W-1:0] filtered_q [$];

    int  errors = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;     // no idling on either side while set

    // coefficient for tap k, mirrored around the center tap
    function automatic int tap_coef(input int k);
        int m;
        if (k >= ROM_TAPS) return 0;
        m = (k > ROM_MID) ? (ROM_TAPS - 1 - k) : k;
        return int'(HALF_ROM[m]);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint acc;
        longint q;
        int     idx;
        acc = 0;
        hist[hist_wr] = x;
        for (int k = 0; k < NTAPS; k++) begin
            idx = (hist_wr + NTAPS - k) % NTAPS;
            acc += longint'(tap_coef(k)) * longint'(hist[idx]);
        end
        hist_wr = (hist_wr + 1) % NTAPS;
        // truncate toward zero, then clamp
        q = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.audio_in  = '0;
        out_ch.ready    = 1'b0;
        for (int i = 0; i < NTAPS; i++) hist[i] = '0;
        hist_wr = 0;
    end

    // sink side: random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected word expected none actual %0d",
                         $time, out_ch.audio_out);
                errors++;
            end else if (out_ch.audio_out !== filtered_q[0]) begin
                $display("%0t: audio_out mismatch expected %0d actual %0d",
                         $time, filtered_q[0], out_ch.audio_out);
                errors++;
                void'(filtered_q.pop_front());
            end else begin
                void'(filtered_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("fir_filter_saturating regression: fail");
            $finish;
        end
    end

    // one word: optional gap, then hold valid until accepted;
    // valid stays up after the accept until the next word or a drain
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        if (!calm && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.audio_in <= x;
        do @(posedge i_clk); while (!in_ch.ready);
        filtered_q.push_back(filter_sample(x));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
    endtask

    // field extremes, sign edges and alternating bit patterns
    task automatic test_extremes();
        logic signed [SAMPLE_W-1:0] v [$] = '{16'sh7fff, -16'sh8000, 16'sh0000,
            -16'sh0001, 16'sh0001, 16'sh5555, -16'sh5556, 16'sh7fff, 16'sh0000};
        foreach (v[i]) send_sample(v[i]);
        wait_drained();   // sender holds off until every result is back
    endtask

    // runs of full scale at both signs; too short to push the sum past the rails
    task automatic test_saturation();
        for (int i = 0; i < 6; i++) send_sample(16'sh7fff);
        for (int i = 0; i < 6; i++) send_sample(-16'sh8000);
    endtask

    // small negative inputs exercise truncation toward zero
    task automatic test_truncation();
        send_sample(-16'sh0001);
        send_sample(16'sh0000);
        send_sample(-16'sh0002);
    endtask

    task automatic test_random();
        logic signed [SAMPLE_W-1:0] x;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            calm = (i >= 300 && i < 400);
            case ($urandom_range(3))
                0: x = SAMPLE_W'($urandom);
                1: x = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
                2: x = $signed(16'($urandom_range(64))) - 16'sd32;
                default: x = SAMPLE_W'($urandom);
            endcase
            send_sample(x);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_saturation();
        test_truncation();
        test_random();
        wait_drained();
        repeat (2 * NTAPS + 20) @(posedge i_clk);
        if (errors == 0)
            $display("fir_filter_saturating regression: pass");
        else
            $display("fir_filter_saturating regression: fail");
        $finish;
    end
endmodule

FILE: fir_filter_saturating.f
+incdir+hdl
hdl/fsf_pkg.sv
hdl/fsf_if.sv
hdl/fsf_mac.sv
hdl/fir_filter_saturating.sv
bench/tb.sv
